// ===== hw/rtl/ccctx_pkg.sv =====
// shared types and constants of the cavlc coefficient count context block
// no dependencies

package ccctx_pkg;

   localparam int unsigned MB_W = 10;
   localparam int unsigned BLK_W = 4;
   localparam int unsigned VAL_W = 5;
   localparam int unsigned CSR_W = 6;
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_W-1:0] CSR_SIZE_RESET = 6'd32;
   localparam int unsigned LUMA_BLKS = 16;
   localparam int unsigned CHROMA_BLKS = 4;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_WRITE     = 2'd0,
      OP_QUERY     = 2'd1,
      OP_QCLEAR    = 2'd2,
      OP_CLEAR_ALL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PLANE_LUMA = 2'd0,
      PLANE_CB   = 2'd1,
      PLANE_CR   = 2'd2,
      PLANE_NONE = 2'd3
   } plane_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH_MBS  = 1'b0,
      CSR_HEIGHT_MBS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_WRITE,
      CMD_QUERY,
      CMD_QZERO,
      CMD_QCLEAR,
      CMD_CLEAR_ALL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      plane_type        plane;
      logic [MB_W-1:0]  mb;
      logic [BLK_W-1:0] blk;
      logic [VAL_W-1:0] count;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_IDX,
      ST_WR,
      ST_QCLR,
      ST_RDL,
      ST_RDU,
      ST_CALC,
      ST_SWEEP
   } back_state_type;

endpackage

// ===== hw/rtl/ccctx_ram.sv =====
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies

module ccctx_ram #(
   parameter int unsigned WIDTH = 5,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/ccctx_front.sv =====
// front end: accepts request transfers, classifies them into commands
// depends on ccctx_pkg

module ccctx_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_operation,
   input  logic [1:0]                   req_plane,
   input  logic                         req_dc_kind,
   input  logic [ccctx_pkg::MB_W-1:0]   req_mb_addr,
   input  logic [ccctx_pkg::BLK_W-1:0]  req_block_idx,
   input  logic [1:0]                   req_quadrant,
   input  logic [ccctx_pkg::VAL_W-1:0]  req_coeff_count,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output ccctx_pkg::cmd_type           cmd_data
);

   import ccctx_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   cmd_type cls;
   logic    keep;
   logic    accept;

   assign req_ready = enable && (!valid_ff || cmd_ready);
   assign accept = req_valid && req_ready;

   always_comb begin
      keep = 1'b1;
      cls.kind = CMD_WRITE;
      cls.plane = plane_type'(req_plane);
      cls.mb = req_mb_addr;
      cls.blk = req_block_idx;
      cls.count = req_coeff_count;
      unique case (op_type'(req_operation))
         OP_WRITE: begin
            cls.kind = CMD_WRITE;
            keep = !req_dc_kind && (cls.plane != PLANE_NONE);
         end
         OP_QUERY: begin
            cls.kind = (cls.plane == PLANE_NONE) ? CMD_QZERO : CMD_QUERY;
         end
         OP_QCLEAR: begin
            cls.kind = CMD_QCLEAR;
            cls.plane = PLANE_LUMA;
            cls.blk = {req_quadrant[1], 1'b0, req_quadrant[0], 1'b0};
            keep = !req_dc_kind;
         end
         OP_CLEAR_ALL: begin
            cls.kind = CMD_CLEAR_ALL;
         end
      endcase
   end

   always_comb begin
      valid_in = (valid_ff && !cmd_ready) || (accept && keep);
      cmd_in = (accept && keep) ? cls : cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd_data = cmd_ff;

endmodule

// ===== hw/rtl/ccctx_queue.sv =====
// command queue between front end and back end
// depends on ccctx_pkg

module ccctx_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ccctx_pkg::cmd_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ccctx_pkg::cmd_type out_data
);

   import ccctx_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   cmd_type          entry_in [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic             push, pop;

   assign in_ready = fill_ff != FILL_W'(QUEUE_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_data = entry_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      entry_in = entry_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = in_data;
      end
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in = fill_ff + FILL_W'(push) - FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
      entry_ff <= entry_in;
   end

endmodule

// ===== hw/rtl/ccctx_div.sv =====
// iterative divider, two quotient bits per cycle, macroblock address by width
// depends on ccctx_pkg

module ccctx_div #(
   parameter int unsigned DIVISOR_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ccctx_pkg::MB_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]       divisor,
   output logic                       done,
   output logic [ccctx_pkg::MB_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]       remainder
);

   import ccctx_pkg::*;

   localparam int unsigned STEPS = MB_W / 2;
   localparam int unsigned STEP_W = $clog2(STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [MB_W-1:0]   quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_step;
   logic [MB_W-1:0]   quo_step;
   logic              last;

   always_comb begin
      logic [DIVISOR_W:0] shifted;
      logic               ge;
      rem_step = rem_ff;
      quo_step = quo_ff;
      for (int k = 0; k < 2; k++) begin
         shifted = {rem_step, quo_step[MB_W-1]};
         ge = shifted >= {1'b0, divisor};
         quo_step = {quo_step[MB_W-2:0], ge};
         rem_step = ge ? DIVISOR_W'(shifted - {1'b0, divisor}) : DIVISOR_W'(shifted);
      end
   end

   assign last = step_ff == STEP_W'(STEPS - 1);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      done_in = busy_ff && last;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in = '0;
         quo_in = dividend;
      end else if (busy_ff) begin
         rem_in = rem_step;
         quo_in = quo_step;
         step_in = step_ff + STEP_W'(1);
         busy_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/ccctx_back.sv =====
// back end: count stores, address arithmetic, query, clears and response register
// depends on ccctx_pkg, ccctx_div, ccctx_ram

module ccctx_back #(
   parameter int unsigned MAX_WIDTH_MBS = 32,
   parameter int unsigned MAX_HEIGHT_MBS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ccctx_pkg::CSR_W-1:0] width_mbs,
   input  logic [ccctx_pkg::CSR_W-1:0] height_mbs,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  ccctx_pkg::cmd_type          cmd_data,
   output logic                        init_busy,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ccctx_pkg::VAL_W-1:0] rsp_nc_value
);

   import ccctx_pkg::*;

   localparam int unsigned CSR_MAX = (1 << CSR_W) - 1;
   localparam int unsigned W_MAX = (MAX_WIDTH_MBS < CSR_MAX) ? MAX_WIDTH_MBS : CSR_MAX;
   localparam int unsigned H_MAX = (MAX_HEIGHT_MBS < CSR_MAX) ? MAX_HEIGHT_MBS : CSR_MAX;
   localparam int unsigned WW = $clog2(W_MAX + 1);
   localparam int unsigned HW = $clog2(H_MAX + 1);
   localparam int unsigned LUMA_DEPTH = LUMA_BLKS * MAX_WIDTH_MBS * MAX_HEIGHT_MBS;
   localparam int unsigned CHROMA_DEPTH = CHROMA_BLKS * MAX_WIDTH_MBS * MAX_HEIGHT_MBS;
   localparam int unsigned LA_W = $clog2(LUMA_DEPTH);
   localparam int unsigned CA_W = $clog2(CHROMA_DEPTH);
   localparam int unsigned SW_W = $clog2(LUMA_DEPTH + 1);
   localparam int unsigned BX_W = WW + 2;
   localparam int unsigned BY_W = MB_W + 2;
   localparam int unsigned ROW_W = WW + 2;
   localparam int unsigned PROD_W = BY_W + ROW_W;
   localparam int unsigned IDX_W = PROD_W + 1;

   function automatic logic in_store(plane_type plane, logic [IDX_W-1:0] addr);
      logic [31:0] limit;
      limit = (plane == PLANE_LUMA) ? LUMA_DEPTH : CHROMA_DEPTH;
      return 32'(addr) < limit;
   endfunction

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [BX_W-1:0]   bx_ff, bx_in;
   logic [BY_W-1:0]   by_ff, by_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              left_ok_ff, left_ok_in;
   logic              up_ok_ff, up_ok_in;
   logic              a_use_ff, a_use_in;
   logic              b_use_ff, b_use_in;
   logic [VAL_W-1:0]  a_ff, a_in;
   logic [1:0]        qsub_ff, qsub_in;
   logic [SW_W-1:0]   sweep_cnt_ff, sweep_cnt_in;
   logic [SW_W-1:0]   sweep_lim_ff, sweep_lim_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_nc_ff, rsp_nc_in;

   logic [WW-1:0]     eff_w;
   logic [HW-1:0]     eff_h;
   logic [WW+HW-1:0]  wh_prod;
   logic              div_start, div_done;
   logic [MB_W-1:0]   div_quo;
   logic [WW-1:0]     div_rem;
   logic [IDX_W-1:0]  op_addr;
   logic              addr_ok;
   logic              sweep_done;
   logic              sweep_chroma;
   logic              pop;
   logic              rsp_load;
   logic              wr_sel, rd_sel;
   logic              luma_we, cb_we, cr_we;
   logic              luma_re, cb_re, cr_re;
   logic [VAL_W-1:0]  wdata;
   logic [LA_W-1:0]   luma_waddr;
   logic [CA_W-1:0]   chroma_waddr;
   logic [VAL_W-1:0]  luma_rdata, cb_rdata, cr_rdata, rdata_sel;
   logic [VAL_W-1:0]  b_val;
   logic [VAL_W:0]    nc_sum;
   logic [VAL_W-1:0]  nc;

   assign eff_w = (width_mbs == '0) ? WW'(1)
                : ((32'(width_mbs) > W_MAX) ? WW'(W_MAX) : WW'(width_mbs));
   assign eff_h = (height_mbs == '0) ? HW'(1)
                : ((32'(height_mbs) > H_MAX) ? HW'(H_MAX) : HW'(height_mbs));
   assign wh_prod = (WW+HW)'(eff_w) * (WW+HW)'(eff_h);

   ccctx_div #(
      .DIVISOR_W(WW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cmd_data.mb),
      .divisor   (eff_w),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign pop = cmd_valid && cmd_ready;
   assign sweep_done = sweep_cnt_ff == (sweep_lim_ff - SW_W'(1));
   assign sweep_chroma = sweep_cnt_ff < (sweep_lim_ff >> 2);
   assign rsp_load = (state_ff == ST_CALC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      unique case (state_ff)
         ST_RDL:  op_addr = idx_ff - IDX_W'(1);
         ST_RDU:  op_addr = idx_ff - IDX_W'(row_ff);
         ST_QCLR: op_addr = idx_ff + (qsub_ff[1] ? IDX_W'(row_ff) : '0) + IDX_W'(qsub_ff[0]);
         default: op_addr = idx_ff;
      endcase
   end

   assign addr_ok = in_store(cmd_ff.plane, op_addr);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.kind)
                  CMD_CLEAR_ALL: state_in = ST_SWEEP;
                  CMD_QZERO:     state_in = ST_CALC;
                  default:       state_in = ST_DIV;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_IDX;
         end
         ST_IDX: begin
            unique case (cmd_ff.kind)
               CMD_WRITE:  state_in = ST_WR;
               CMD_QUERY:  state_in = ST_RDL;
               CMD_QCLEAR: state_in = ST_QCLR;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_WR: begin
            state_in = ST_IDLE;
         end
         ST_QCLR: begin
            if (qsub_ff == 2'b11) state_in = ST_IDLE;
         end
         ST_RDL: begin
            state_in = ST_RDU;
         end
         ST_RDU: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (sweep_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      cmd_ready = 1'b0;
      div_start = 1'b0;
      wr_sel = 1'b0;
      rd_sel = 1'b0;
      luma_we = 1'b0;
      cb_we = 1'b0;
      cr_we = 1'b0;
      wdata = '0;
      luma_waddr = LA_W'(op_addr);
      chroma_waddr = CA_W'(op_addr);
      unique case (state_ff)
         ST_INIT, ST_SWEEP: begin
            luma_we = 1'b1;
            cb_we = sweep_chroma;
            cr_we = sweep_chroma;
            luma_waddr = LA_W'(sweep_cnt_ff);
            chroma_waddr = CA_W'(sweep_cnt_ff);
         end
         ST_IDLE: begin
            cmd_ready = 1'b1;
            div_start = cmd_valid && (cmd_data.kind == CMD_WRITE
               || cmd_data.kind == CMD_QUERY || cmd_data.kind == CMD_QCLEAR);
         end
         ST_WR: begin
            wr_sel = addr_ok;
            wdata = cmd_ff.count;
         end
         ST_QCLR: begin
            wr_sel = addr_ok;
         end
         ST_RDL: begin
            rd_sel = left_ok_ff && addr_ok;
         end
         ST_RDU: begin
            rd_sel = up_ok_ff && addr_ok;
         end
         default: begin
         end
      endcase
      if (wr_sel) begin
         luma_we = cmd_ff.plane == PLANE_LUMA;
         cb_we = cmd_ff.plane == PLANE_CB;
         cr_we = cmd_ff.plane == PLANE_CR;
      end
   end

   assign luma_re = rd_sel && (cmd_ff.plane == PLANE_LUMA);
   assign cb_re = rd_sel && (cmd_ff.plane == PLANE_CB);
   assign cr_re = rd_sel && (cmd_ff.plane == PLANE_CR);

   ccctx_ram #(
      .WIDTH (VAL_W),
      .DEPTH (LUMA_DEPTH)
   ) u_luma_ram (
      .clock (clock),
      .we    (luma_we),
      .waddr (luma_waddr),
      .wdata (wdata),
      .re    (luma_re),
      .raddr (LA_W'(op_addr)),
      .rdata (luma_rdata)
   );

   ccctx_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CHROMA_DEPTH)
   ) u_cb_ram (
      .clock (clock),
      .we    (cb_we),
      .waddr (chroma_waddr),
      .wdata (wdata),
      .re    (cb_re),
      .raddr (CA_W'(op_addr)),
      .rdata (cb_rdata)
   );

   ccctx_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CHROMA_DEPTH)
   ) u_cr_ram (
      .clock (clock),
      .we    (cr_we),
      .waddr (chroma_waddr),
      .wdata (wdata),
      .re    (cr_re),
      .raddr (CA_W'(op_addr)),
      .rdata (cr_rdata)
   );

   always_comb begin
      unique case (cmd_ff.plane)
         PLANE_LUMA: rdata_sel = luma_rdata;
         PLANE_CB:   rdata_sel = cb_rdata;
         PLANE_CR:   rdata_sel = cr_rdata;
         default:    rdata_sel = '0;
      endcase
   end

   // neighbor average with rounding when both neighbors exist, else the one that exists, else zero
   assign b_val = b_use_ff ? rdata_sel : '0;
   assign nc_sum = {1'b0, a_ff} + {1'b0, b_val} + (VAL_W+1)'(1);

   always_comb begin
      priority if (left_ok_ff && up_ok_ff) begin
         nc = nc_sum[VAL_W:1];
      end else if (left_ok_ff) begin
         nc = a_ff;
      end else if (up_ok_ff) begin
         nc = b_val;
      end else begin
         nc = '0;
      end
   end

   // datapath registers
   always_comb begin
      cmd_in = pop ? cmd_data : cmd_ff;
      bx_in = bx_ff;
      by_in = by_ff;
      row_in = row_ff;
      if (state_ff == ST_DIV && div_done) begin
         if (cmd_ff.plane == PLANE_LUMA) begin
            bx_in = {div_rem, cmd_ff.blk[1:0]};
            by_in = {div_quo, cmd_ff.blk[3:2]};
            row_in = {eff_w, 2'b00};
         end else begin
            bx_in = {1'b0, div_rem, cmd_ff.blk[0]};
            by_in = {1'b0, div_quo, cmd_ff.blk[1]};
            row_in = {1'b0, eff_w, 1'b0};
         end
      end
      prod_in = PROD_W'(by_ff) * PROD_W'(row_ff);
      idx_in = IDX_W'(prod_ff) + IDX_W'(bx_ff);
      left_ok_in = left_ok_ff;
      up_ok_in = up_ok_ff;
      if (pop) begin
         left_ok_in = 1'b0;
         up_ok_in = 1'b0;
      end else if (state_ff == ST_IDX) begin
         left_ok_in = bx_ff != '0;
         up_ok_in = by_ff != '0;
      end
      a_use_in = (state_ff == ST_RDL) ? rd_sel : a_use_ff;
      b_use_in = (state_ff == ST_RDU) ? rd_sel : b_use_ff;
      a_in = (state_ff == ST_RDU) ? (a_use_ff ? rdata_sel : '0) : a_ff;
      qsub_in = (state_ff == ST_QCLR) ? qsub_ff + 2'd1 : 2'd0;
      sweep_cnt_in = (state_ff == ST_INIT || state_ff == ST_SWEEP)
                   ? sweep_cnt_ff + SW_W'(1) : '0;
      sweep_lim_in = (pop && cmd_data.kind == CMD_CLEAR_ALL)
                   ? SW_W'({wh_prod, 4'b0000}) : sweep_lim_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_nc_in = rsp_load ? nc : rsp_nc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sweep_cnt_ff <= '0;
         sweep_lim_ff <= SW_W'(LUMA_DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         sweep_lim_ff <= sweep_lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
      row_ff <= row_in;
      prod_ff <= prod_in;
      idx_ff <= idx_in;
      left_ok_ff <= left_ok_in;
      up_ok_ff <= up_ok_in;
      a_use_ff <= a_use_in;
      b_use_ff <= b_use_in;
      a_ff <= a_in;
      qsub_ff <= qsub_in;
      rsp_nc_ff <= rsp_nc_in;
   end

   assign init_busy = state_ff == ST_INIT;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_nc_value = rsp_nc_ff;

endmodule

// ===== hw/rtl/cavlc_coeff_count_context.sv =====
// top level of the cavlc coefficient count context block
// depends on ccctx_pkg, ccctx_front, ccctx_queue, ccctx_back
//
// Stores nonzero coefficient counts of every 4x4 block of a picture (luma, Cb, Cr)
// and answers nC context queries from the left and upper neighbor blocks.
// Request channel (req_*): write a count, query nC, clear a luma 8x8 quadrant or
// clear the whole picture area. Only a query produces a response transfer (rsp_*).
// Register port (csr_*): index 0 picture width, index 1 picture height, in
// macroblocks; always ready. The user must write it only while the block has
// nothing in flight; the block itself does not enforce this. A front stage
// classifies requests into a two-entry command queue; the back end executes one
// command at a time. Macroblock address to position goes through an iterative
// divider at two bits per cycle, then a registered multiply and a registered add.
// A quadrant clear makes four single-port writes, and a full clear sweeps one luma
// entry per cycle with both chroma stores swept alongside. Neighbor counts come
// from two reads of one ram port. After reset the stores are swept over all
// 16*MAX_WIDTH_MBS*MAX_HEIGHT_MBS luma entries; req_ready stays low until that
// sweep is done. A stalled response sits in the output register while the queue
// keeps taking requests until it fills.

module cavlc_coeff_count_context #(
   parameter int unsigned MAX_WIDTH_MBS = 32,
   parameter int unsigned MAX_HEIGHT_MBS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [1:0]                      req_plane,
   input  logic                            req_dc_kind,
   input  logic [ccctx_pkg::MB_W-1:0]      req_mb_addr,
   input  logic [ccctx_pkg::BLK_W-1:0]     req_block_idx,
   input  logic [1:0]                      req_quadrant,
   input  logic [ccctx_pkg::VAL_W-1:0]     req_coeff_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ccctx_pkg::VAL_W-1:0]     rsp_nc_value,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ccctx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ccctx_pkg::CSR_W-1:0]     csr_wdata
);

   import ccctx_pkg::*;

   logic [CSR_W-1:0] width_mbs_ff, width_mbs_in;
   logic [CSR_W-1:0] height_mbs_ff, height_mbs_in;
   logic             init_busy;
   logic             front_valid, front_ready;
   cmd_type          front_cmd;
   logic             queue_valid, queue_ready;
   cmd_type          queue_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      width_mbs_in = width_mbs_ff;
      height_mbs_in = height_mbs_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH_MBS:  width_mbs_in = csr_wdata;
            CSR_HEIGHT_MBS: height_mbs_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_mbs_ff <= CSR_SIZE_RESET;
         height_mbs_ff <= CSR_SIZE_RESET;
      end else begin
         width_mbs_ff <= width_mbs_in;
         height_mbs_ff <= height_mbs_in;
      end
   end

   ccctx_front u_front (
      .clock           (clock),
      .reset           (reset),
      .enable          (!init_busy),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_plane       (req_plane),
      .req_dc_kind     (req_dc_kind),
      .req_mb_addr     (req_mb_addr),
      .req_block_idx   (req_block_idx),
      .req_quadrant    (req_quadrant),
      .req_coeff_count (req_coeff_count),
      .cmd_valid       (front_valid),
      .cmd_ready       (front_ready),
      .cmd_data        (front_cmd)
   );

   ccctx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_cmd)
   );

   ccctx_back #(
      .MAX_WIDTH_MBS  (MAX_WIDTH_MBS),
      .MAX_HEIGHT_MBS (MAX_HEIGHT_MBS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .width_mbs    (width_mbs_ff),
      .height_mbs   (height_mbs_ff),
      .cmd_valid    (queue_valid),
      .cmd_ready    (queue_ready),
      .cmd_data     (queue_cmd),
      .init_busy    (init_busy),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_nc_value (rsp_nc_value)
   );

endmodule

// ===== tb/sv/cavlc_coeff_count_context_test.sv =====
// self-checking testbench of the cavlc coefficient count context block
// depends on ccctx_pkg and cavlc_coeff_count_context; holds its own count store predictor

module cavlc_coeff_count_context_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ccctx_pkg::*;

   localparam int unsigned MAX_W = 32;
   localparam int unsigned MAX_H = 32;
   localparam int unsigned LUMA_ENTRIES = LUMA_BLKS * MAX_W * MAX_H;
   localparam int unsigned CHROMA_ENTRIES = CHROMA_BLKS * MAX_W * MAX_H;
   localparam int unsigned STALL_LIMIT = 250000;
   localparam int unsigned RSP_HOLD = 400;
   localparam int unsigned ITEMS_PER_PHASE = 200;
   localparam int unsigned NUM_ROWS = 25;
   localparam int unsigned NUM_PHASES = 6;

   typedef struct {
      op_type      op;
      plane_type   plane;
      bit          dc;
      int unsigned mb;
      int unsigned blk;
      int unsigned quad;
      int unsigned cnt;
      bit          known;
      int unsigned nc;
   } req_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_operation;
   logic [1:0]           req_plane;
   logic                 req_dc_kind;
   logic [MB_W-1:0]      req_mb_addr;
   logic [BLK_W-1:0]     req_block_idx;
   logic [1:0]           req_quadrant;
   logic [VAL_W-1:0]     req_coeff_count;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [VAL_W-1:0]     rsp_nc_value;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   logic [VAL_W-1:0] luma_cnt [LUMA_ENTRIES];
   logic [VAL_W-1:0] cb_cnt [CHROMA_ENTRIES];
   logic [VAL_W-1:0] cr_cnt [CHROMA_ENTRIES];
   int unsigned      width_reg;
   int unsigned      height_reg;

   logic [VAL_W-1:0] nc_expected [$];
   bit               recent_clear [$];
   req_row_type      directed_rows [NUM_ROWS];
   int unsigned      phase_w [NUM_PHASES] = '{1, 4, 0, 63, 11, 32};
   int unsigned      phase_h [NUM_PHASES] = '{1, 3, 0, 40, 7, 32};

   int unsigned mismatches = 0;
   int unsigned stall_cycles = 0;
   int unsigned n_requests = 0;
   int unsigned n_checked = 0;
   int unsigned n_sweeps = 0;
   bit          idle_on = 1'b1;
   bit          hold_rsp = 1'b0;
   bit          last_valid = 1'b0;
   int unsigned last_plane, last_mb, last_blk;

   cavlc_coeff_count_context #(
      .MAX_WIDTH_MBS(MAX_W),
      .MAX_HEIGHT_MBS(MAX_H)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_plane(req_plane),
      .req_dc_kind(req_dc_kind),
      .req_mb_addr(req_mb_addr),
      .req_block_idx(req_block_idx),
      .req_quadrant(req_quadrant),
      .req_coeff_count(req_coeff_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_nc_value(rsp_nc_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned eff_size(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   function automatic int unsigned stored_count(int unsigned plane, int unsigned idx);
      if (plane == PLANE_LUMA) return (idx < LUMA_ENTRIES) ? luma_cnt[idx] : 0;
      if (plane == PLANE_CB) return (idx < CHROMA_ENTRIES) ? cb_cnt[idx] : 0;
      if (plane == PLANE_CR) return (idx < CHROMA_ENTRIES) ? cr_cnt[idx] : 0;
      return 0;
   endfunction

   function automatic void store_count(int unsigned plane, int unsigned mb,
                                       int unsigned blk, int unsigned val);
      int unsigned w, mx, my, idx;
      w = eff_size(width_reg, MAX_W);
      mx = mb % w;
      my = mb / w;
      if (plane == PLANE_LUMA) begin
         idx = (my * 4 + ((blk >> 2) & 3)) * (w * 4) + mx * 4 + (blk & 3);
         if (idx < LUMA_ENTRIES) luma_cnt[idx] = val[VAL_W-1:0];
      end else begin
         idx = (my * 2 + ((blk >> 1) & 1)) * (w * 2) + mx * 2 + (blk & 1);
         if (plane == PLANE_CB && idx < CHROMA_ENTRIES) cb_cnt[idx] = val[VAL_W-1:0];
         if (plane == PLANE_CR && idx < CHROMA_ENTRIES) cr_cnt[idx] = val[VAL_W-1:0];
      end
   endfunction

   function automatic int unsigned neighbor_nc(int unsigned plane, int unsigned mb,
                                               int unsigned blk);
      int unsigned w, mx, my, bx, by, row, idx, a, b;
      if (plane == PLANE_NONE) return 0;
      w = eff_size(width_reg, MAX_W);
      mx = mb % w;
      my = mb / w;
      if (plane == PLANE_LUMA) begin
         bx = mx * 4 + (blk & 3);
         by = my * 4 + ((blk >> 2) & 3);
         row = w * 4;
      end else begin
         bx = mx * 2 + (blk & 1);
         by = my * 2 + ((blk >> 1) & 1);
         row = w * 2;
      end
      idx = by * row + bx;
      a = (bx != 0) ? stored_count(plane, idx - 1) : 0;
      b = (by != 0) ? stored_count(plane, idx - row) : 0;
      if (bx != 0 && by != 0) return ((a + b + 1) >> 1) & 31;
      if (bx != 0) return a;
      if (by != 0) return b;
      return 0;
   endfunction

   function automatic void apply_request(int unsigned op, int unsigned plane, bit dc,
                                         int unsigned mb, int unsigned blk,
                                         int unsigned quad, int unsigned cnt,
                                         output bit has_rsp, output int unsigned nc);
      int unsigned y0, x0, n;
      has_rsp = 1'b0;
      nc = 0;
      case (op)
         OP_WRITE: begin
            if (!dc && plane != PLANE_NONE) store_count(plane, mb, blk, cnt & 31);
         end
         OP_QUERY: begin
            has_rsp = 1'b1;
            nc = neighbor_nc(plane, mb, blk);
         end
         OP_QCLEAR: begin
            if (!dc) begin
               y0 = (quad >> 1) * 2;
               x0 = (quad & 1) * 2;
               for (int dy = 0; dy < 2; dy++)
                  for (int dx = 0; dx < 2; dx++)
                     store_count(PLANE_LUMA, mb, (y0 + dy) * 4 + x0 + dx, 0);
            end
         end
         default: begin
            n = eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H);
            for (int unsigned i = 0; i < LUMA_BLKS * n; i++) luma_cnt[i] = '0;
            for (int unsigned i = 0; i < CHROMA_BLKS * n; i++) begin
               cb_cnt[i] = '0;
               cr_cnt[i] = '0;
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_request(op_type op, plane_type plane, bit dc, int unsigned mb,
                               int unsigned blk, int unsigned quad, int unsigned cnt,
                               bit known, int unsigned known_nc);
      bit          has_rsp;
      int unsigned nc;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_plane <= plane;
      req_dc_kind <= dc;
      req_mb_addr <= mb[MB_W-1:0];
      req_block_idx <= blk[BLK_W-1:0];
      req_quadrant <= quad[1:0];
      req_coeff_count <= cnt[VAL_W-1:0];
      do @(posedge clock); while (!req_ready);
      apply_request(op, plane, dc, mb, blk, quad, cnt, has_rsp, nc);
      if (has_rsp) nc_expected.push_back(known ? known_nc[VAL_W-1:0] : nc[VAL_W-1:0]);
      recent_clear.push_back(op == OP_CLEAR_ALL);
      if (op == OP_CLEAR_ALL) n_sweeps++;
      n_requests++;
      @(negedge clock);
   endtask

   task automatic random_request();
      int unsigned w, pic, r, op, plane, mb, blk, quad, cnt;
      bit          dc;
      w = eff_size(width_reg, MAX_W);
      pic = w * eff_size(height_reg, MAX_H);
      r = $urandom_range(0, 999);
      if (r < ((pic <= 64) ? 15 : 4)) op = OP_CLEAR_ALL;
      else if (r < 450) op = OP_WRITE;
      else if (r < 880) op = OP_QUERY;
      else op = OP_QCLEAR;
      plane = ($urandom_range(0, 19) == 0) ? PLANE_NONE : $urandom_range(0, 2);
      dc = ($urandom_range(0, 9) == 0);
      mb = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, pic - 1);
      blk = $urandom_range(0, 15);
      quad = $urandom_range(0, 3);
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
      // aim most queries just right of or below a block that was written
      if (op == OP_QUERY && last_valid && $urandom_range(0, 2) != 0) begin
         plane = last_plane;
         mb = last_mb;
         case ($urandom_range(0, 3))
            0: blk = last_blk + 1;
            1: blk = last_blk + ((plane == PLANE_LUMA) ? 4 : 2);
            2: mb = last_mb + 1;
            default: mb = last_mb + w;
         endcase
      end
      send_request(op_type'(op), plane_type'(plane), dc, mb & 1023, blk & 15, quad, cnt,
                   1'b0, 0);
      if (op == OP_WRITE && !dc) begin
         last_valid = 1'b1;
         last_plane = plane;
         last_mb = mb & 1023;
         last_blk = blk & 15;
      end
   endtask

   // waits out every outstanding response and any sweep still running
   task automatic drain();
      int unsigned sweeps;
      req_valid <= 1'b0;
      while (nc_expected.size() != 0) @(negedge clock);
      sweeps = 0;
      foreach (recent_clear[i]) if (recent_clear[i]) sweeps++;
      // at most one command in the back end, QUEUE_DEPTH in the queue and one in the front register
      if (sweeps > QUEUE_DEPTH + 2) sweeps = QUEUE_DEPTH + 2;
      repeat (sweeps * (LUMA_BLKS * eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H)
                        + 1) + 100) @(negedge clock);
      recent_clear.delete();
   endtask

   task automatic set_size(int unsigned w, int unsigned h);
      for (int i = 0; i < 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= (i == 0) ? CSR_WIDTH_MBS : CSR_HEIGHT_MBS;
         csr_wdata <= (i == 0) ? w[CSR_W-1:0] : h[CSR_W-1:0];
         do @(posedge clock); while (!csr_ready);
         if (i == 0) width_reg = w & 63;
         else height_reg = h & 63;
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      last_valid = 1'b0;
   endtask

   // response side: random stalls and one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 15) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (nc_expected.size() == 0) begin
            report_mismatch("response transfer with none expected", rsp_nc_value, 0);
         end else begin
            if (rsp_nc_value !== nc_expected[0])
               report_mismatch("nc_value", rsp_nc_value, nc_expected[0]);
            void'(nc_expected.pop_front());
            n_checked++;
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d responses outstanding",
                  stall_cycles, nc_expected.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      directed_rows = '{
         '{OP_QUERY,     PLANE_LUMA, 1'b0,    0,  0, 0,  0, 1'b1,  0},
         '{OP_WRITE,     PLANE_LUMA, 1'b0,    0,  0, 0, 16, 1'b0,  0},
         '{OP_WRITE,     PLANE_LUMA, 1'b0,    0,  1, 0, 31, 1'b0,  0},
         '{OP_QUERY,     PLANE_LUMA, 1'b0,    0,  1, 0,  0, 1'b1, 16},
         '{OP_QUERY,     PLANE_LUMA, 1'b0,    0,  2, 0,  0, 1'b1, 31},
         '{OP_WRITE,     PLANE_LUMA, 1'b0,    0,  4, 0,  5, 1'b0,  0},
         '{OP_QUERY,     PLANE_LUMA, 1'b0,    0,  5, 0,  0, 1'b0,  0},
         '{OP_WRITE,     PLANE_LUMA, 1'b1,    0,  4, 0,  0, 1'b0,  0},
         '{OP_QUERY,     PLANE_LUMA, 1'b1,    0,  5, 0,  0, 1'b0,  0},
         '{OP_WRITE,     PLANE_CB,   1'b0,    1,  0, 0,  9, 1'b0,  0},
         '{OP_QUERY,     PLANE_CB,   1'b0,    1,  1, 0,  0, 1'b1,  9},
         '{OP_WRITE,     PLANE_CR,   1'b0,    0,  5, 0, 12, 1'b0,  0},
         '{OP_QUERY,     PLANE_CR,   1'b0,    1, 12, 0,  0, 1'b1, 12},
         '{OP_WRITE,     PLANE_NONE, 1'b0,    0,  0, 0,  7, 1'b0,  0},
         '{OP_QUERY,     PLANE_NONE, 1'b0,    0,  5, 0,  0, 1'b1,  0},
         '{OP_QCLEAR,    PLANE_CB,   1'b0,    0,  0, 0,  0, 1'b0,  0},
         '{OP_QUERY,     PLANE_LUMA, 1'b0,    0,  2, 0,  0, 1'b1,  0},
         '{OP_WRITE,     PLANE_LUMA, 1'b0,    0, 10, 0, 20, 1'b0,  0},
         '{OP_QCLEAR,    PLANE_LUMA, 1'b1,    0,  0, 3,  0, 1'b0,  0},
         '{OP_QUERY,     PLANE_LUMA, 1'b0,    0, 11, 0,  0, 1'b0,  0},
         '{OP_CLEAR_ALL, PLANE_LUMA, 1'b0,    0,  0, 0,  0, 1'b0,  0},
         '{OP_QUERY,     PLANE_LUMA, 1'b0,    0, 11, 0,  0, 1'b1,  0},
         '{OP_WRITE,     PLANE_LUMA, 1'b0, 1023, 14, 0, 16, 1'b0,  0},
         '{OP_QUERY,     PLANE_LUMA, 1'b0, 1023, 15, 0,  0, 1'b0,  0},
         '{OP_QUERY,     PLANE_CB,   1'b0, 1023,  3, 0,  0, 1'b0,  0}
      };
      foreach (luma_cnt[i]) luma_cnt[i] = '0;
      foreach (cb_cnt[i]) cb_cnt[i] = '0;
      foreach (cr_cnt[i]) cr_cnt[i] = '0;
      width_reg = CSR_SIZE_RESET;
      height_reg = CSR_SIZE_RESET;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_WRITE;
      req_plane = PLANE_LUMA;
      req_dc_kind = 1'b0;
      req_mb_addr = '0;
      req_block_idx = '0;
      req_quadrant = '0;
      req_coeff_count = '0;
      csr_valid = 1'b0;
      csr_index = CSR_WIDTH_MBS;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].plane, directed_rows[i].dc,
                      directed_rows[i].mb, directed_rows[i].blk, directed_rows[i].quad,
                      directed_rows[i].cnt, directed_rows[i].known, directed_rows[i].nc);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         set_size(phase_w[p], phase_h[p]);
         if (p == 1) hold_rsp = 1'b1;
         if (p == NUM_PHASES - 1) idle_on = 1'b0;
         repeat (ITEMS_PER_PHASE) random_request();
      end
      drain();

      $display("covered %0d requests with %0d nc responses checked, %0d full clears",
               n_requests, n_checked, n_sweeps);
      $display("picture sizes went from 1x1 to 32x32, including zero and above-max settings");
      if (mismatches == 0 && nc_expected.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
